// ----- rtl/mmb_pkg.sv -----
// shared types, constants and address decode for the memory map bus
package mmb_pkg;

    localparam int ROM_AW  = 15;
    localparam int EXT_AW  = 13;
    localparam int MAIN_AW = 15;
    localparam int CNT_W   = 15;

    localparam int DMA_LENGTH = 160;

    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_LOAD  = 2'd2;

    localparam logic [15:0] ADDR_EXT_LO  = 16'hA000;
    localparam logic [15:0] ADDR_EXT_HI  = 16'hBFFF;
    localparam logic [15:0] ADDR_ECHO_LO = 16'hE000;
    localparam logic [15:0] ADDR_ECHO_HI = 16'hFDFF;
    localparam logic [15:0] ADDR_ZERO_LO = 16'hFEA0;
    localparam logic [15:0] ADDR_ZERO_HI = 16'hFEFF;
    localparam logic [15:0] ECHO_OFFSET  = 16'h2000;

    localparam logic [15:0] ADDR_SB  = 16'hFF01;
    localparam logic [15:0] ADDR_SC  = 16'hFF02;
    localparam logic [15:0] ADDR_DIV = 16'hFF04;
    localparam logic [15:0] ADDR_TAC = 16'hFF07;
    localparam logic [15:0] ADDR_IF  = 16'hFF0F;
    localparam logic [15:0] ADDR_DMA = 16'hFF46;
    localparam logic [15:0] ADDR_IE  = 16'hFFFF;

    localparam logic [7:0] SERIAL_START = 8'h81;
    localparam logic [7:0] TAC_MASK     = 8'b0000_0111;

    // main ram index of FE00
    localparam logic [MAIN_AW-1:0] OAM_BASE = 15'h7E00;

    typedef enum logic [1:0] {
        FWD_NONE = 2'd0,
        FWD_DIV  = 2'd1,
        FWD_IF   = 2'd2,
        FWD_IE   = 2'd3
    } t_fwd;

    typedef enum logic [2:0] {
        REG_ROM,
        REG_EXT,
        REG_ECHO,
        REG_ZERO,
        REG_MAIN
    } t_region;

    typedef struct packed {
        logic              we;
        logic [ROM_AW-1:0] waddr;
        logic [7:0]        wdata;
        logic [ROM_AW-1:0] raddr;
    } t_rom_port;

    typedef struct packed {
        logic              we;
        logic [EXT_AW-1:0] waddr;
        logic [7:0]        wdata;
        logic [EXT_AW-1:0] raddr;
    } t_ext_port;

    typedef struct packed {
        logic               we;
        logic [MAIN_AW-1:0] waddr;
        logic [7:0]         wdata;
        logic [MAIN_AW-1:0] raddr;
    } t_main_port;

    function automatic t_region addr_region(input logic [15:0] a);
        if (!a[15]) begin
            return REG_ROM;
        end else if (a >= ADDR_EXT_LO && a <= ADDR_EXT_HI) begin
            return REG_EXT;
        end else if (a >= ADDR_ECHO_LO && a <= ADDR_ECHO_HI) begin
            return REG_ECHO;
        end else if (a >= ADDR_ZERO_LO && a <= ADDR_ZERO_HI) begin
            return REG_ZERO;
        end else begin
            return REG_MAIN;
        end
    endfunction

    // echo folds down by 2000, main ram is addressed by the low bits
    function automatic logic [MAIN_AW-1:0] main_index(input logic [15:0] a);
        logic [15:0] m;
        m = (addr_region(a) == REG_ECHO) ? a - ECHO_OFFSET : a;
        return m[MAIN_AW-1:0];
    endfunction

endpackage

// ----- rtl/mmb_ram.sv -----
// generic single-write, single-read synchronous ram with registered read data
module mmb_ram #(
    parameter int AW = 8,
    parameter int DW = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] mem [2**AW];
    logic [DW-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_q <= mem[i_raddr];
    end

    assign o_rdata = r_q;

endmodule

// ----- rtl/mmb_seq.sv -----
// access sequencer: clearing pass, bus decode, oam dma copy and result register
module mmb_seq (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [1:0]                i_op,
    input  logic [15:0]               i_addr,
    input  logic [7:0]                i_wdata,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [7:0]                o_rdata,
    output logic                      o_serial_valid,
    output logic [7:0]                o_serial_char,
    output logic [1:0]                o_fwd_target,
    output logic [7:0]                o_fwd_value,
    output mmb_pkg::t_rom_port        o_rom,
    output mmb_pkg::t_ext_port        o_ext,
    output mmb_pkg::t_main_port       o_main,
    input  logic [7:0]                i_rom_q,
    input  logic [7:0]                i_ext_q,
    input  logic [7:0]                i_main_q
);
    import mmb_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_DMA_RD,
        S_DMA_WR,
        S_RESP
    } t_state;

    t_state           r_state;
    logic [CNT_W-1:0] r_cnt;
    logic [1:0]       r_op;
    logic [15:0]      r_addr;
    logic [7:0]       r_wdata;
    logic             r_out_valid;
    logic [7:0]       r_out_rdata;
    logic             r_out_serial_valid;
    logic [7:0]       r_out_serial_char;
    t_fwd             r_out_fwd_target;
    logic [7:0]       r_out_fwd_value;

    logic        is_write;
    logic        is_serial;
    logic        in_dma;
    logic [15:0] rd_a;
    t_region     rd_region;
    logic [7:0]  rd_sel;
    t_fwd        fwd;
    logic        main_special;
    logic        out_free;

    assign is_write  = (r_op == OP_WRITE);
    assign is_serial = is_write && r_addr == ADDR_SC && r_wdata == SERIAL_START;
    assign in_dma    = (r_state == S_DMA_RD) || (r_state == S_DMA_WR);
    assign out_free  = !r_out_valid || !i_out_stall;

    always_comb begin
        if (in_dma) begin
            rd_a = {r_wdata, r_cnt[7:0]};
        end else if (is_serial) begin
            rd_a = ADDR_SB;
        end else begin
            rd_a = r_addr;
        end
        rd_region = addr_region(rd_a);
        case (rd_region)
            REG_ROM:  rd_sel = i_rom_q;
            REG_EXT:  rd_sel = i_ext_q;
            REG_ZERO: rd_sel = 8'h00;
            default:  rd_sel = i_main_q;
        endcase
    end

    always_comb begin
        fwd = FWD_NONE;
        if (is_write) begin
            unique case (r_addr)
                ADDR_DIV: fwd = FWD_DIV;
                ADDR_IF:  fwd = FWD_IF;
                ADDR_IE:  fwd = FWD_IE;
                default:  fwd = FWD_NONE;
            endcase
        end
        main_special = is_serial || fwd != FWD_NONE || r_addr == ADDR_DMA;
    end

    // memory ports
    always_comb begin
        o_rom.we     = 1'b0;
        o_rom.waddr  = r_addr[ROM_AW-1:0];
        o_rom.wdata  = r_wdata;
        o_rom.raddr  = rd_a[ROM_AW-1:0];
        o_ext.we     = 1'b0;
        o_ext.waddr  = r_addr[EXT_AW-1:0];
        o_ext.wdata  = r_wdata;
        o_ext.raddr  = rd_a[EXT_AW-1:0];
        o_main.we    = 1'b0;
        o_main.waddr = main_index(r_addr);
        o_main.wdata = r_wdata;
        o_main.raddr = main_index(rd_a);
        case (r_state)
            S_CLEAR: begin
                o_main.we    = 1'b1;
                o_main.waddr = r_cnt[MAIN_AW-1:0];
                o_main.wdata = 8'h00;
                o_ext.we     = 1'b1;
                o_ext.waddr  = r_cnt[EXT_AW-1:0];
                o_ext.wdata  = 8'h00;
            end
            S_EXEC: begin
                if (r_op == OP_LOAD) begin
                    o_rom.we = !r_addr[15];
                end else if (is_write) begin
                    case (addr_region(r_addr))
                        REG_EXT:  o_ext.we = 1'b1;
                        REG_ECHO: o_main.we = 1'b1;
                        REG_MAIN: begin
                            o_main.we = !main_special;
                            if (r_addr == ADDR_TAC) begin
                                o_main.wdata = r_wdata & TAC_MASK;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_DMA_WR: begin
                o_main.we    = 1'b1;
                o_main.waddr = OAM_BASE + MAIN_AW'(r_cnt[7:0]);
                o_main.wdata = rd_sel;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // the response step sets valid itself when it loads a new result
            if (r_out_valid && !i_out_stall && r_state != S_RESP) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == '1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_op    <= i_op;
                        r_addr  <= i_addr;
                        r_wdata <= i_wdata;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_cnt <= '0;
                    if (is_write && r_addr == ADDR_DMA) begin
                        r_state <= S_DMA_RD;
                    end else begin
                        r_state <= S_RESP;
                    end
                end
                S_DMA_RD: begin
                    r_state <= S_DMA_WR;
                end
                S_DMA_WR: begin
                    if (r_cnt == CNT_W'(DMA_LENGTH - 1)) begin
                        r_cnt   <= '0;
                        r_state <= S_RESP;
                    end else begin
                        r_cnt   <= r_cnt + 1'b1;
                        r_state <= S_DMA_RD;
                    end
                end
                S_RESP: begin
                    if (out_free) begin
                        r_out_valid        <= 1'b1;
                        r_out_rdata        <= (r_op == OP_READ) ? rd_sel : 8'h00;
                        r_out_serial_valid <= is_serial;
                        r_out_serial_char  <= is_serial ? rd_sel : 8'h00;
                        r_out_fwd_target   <= fwd;
                        r_out_fwd_value    <= (fwd != FWD_NONE) ? r_wdata : 8'h00;
                        r_state            <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_rdata        = r_out_rdata;
    assign o_serial_valid = r_out_serial_valid;
    assign o_serial_char  = r_out_serial_char;
    assign o_fwd_target   = r_out_fwd_target;
    assign o_fwd_value    = r_out_fwd_value;

    a_result_from_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_RESP)
        else $error("result appeared outside the response step");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !(o_main.we || o_ext.we || o_rom.we))
        else $error("memory write while idle");

    a_clear_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !r_out_valid)
        else $error("result during clearing pass");

    a_dma_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_dma |-> r_cnt < CNT_W'(DMA_LENGTH))
        else $error("dma count out of range");

    a_serial_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_serial_valid |-> r_out_fwd_target == FWD_NONE)
        else $error("serial and forwarded write in one result");

endmodule

// ----- rtl/memory_map_bus_with_oam_dma.sv -----
// top level of the byte-wide memory map bus with oam dma
// Byte-wide bus for a 16-bit address map. ROM (0000-7FFF, loaded with op 2),
// external ram (A000-BFFF) and main ram (8000-FFFF, echo E000-FDFF mirrors
// C000-DDFF) each sit in their own synchronous ram with registered read data.
// After reset a clearing pass zeroes main and external ram; no transfer is
// taken until it ends. An ordinary access goes from input transfer to result
// through accept, memory access and result register steps, and the next input
// is taken only once the result is registered.
// A write of FF46 runs the oam dma copy through the read map, a read step and a
// main ram write step for each of the 160 bytes, then registers its result.
// The result register lets the input side run on while a result waits.
module memory_map_bus_with_oam_dma (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_op,
    input  logic [15:0] i_addr,
    input  logic [7:0]  i_wdata,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_rdata,
    output logic        o_serial_valid,
    output logic [7:0]  o_serial_char,
    output logic [1:0]  o_fwd_target,
    output logic [7:0]  o_fwd_value
);
    import mmb_pkg::*;

    t_rom_port  rom_port;
    t_ext_port  ext_port;
    t_main_port main_port;
    logic [7:0] rom_q;
    logic [7:0] ext_q;
    logic [7:0] main_q;

    // sequencer: decode, dma loop and result register
    mmb_seq u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_op           (i_op),
        .i_addr         (i_addr),
        .i_wdata        (i_wdata),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_rdata        (o_rdata),
        .o_serial_valid (o_serial_valid),
        .o_serial_char  (o_serial_char),
        .o_fwd_target   (o_fwd_target),
        .o_fwd_value    (o_fwd_value),
        .o_rom          (rom_port),
        .o_ext          (ext_port),
        .o_main         (main_port),
        .i_rom_q        (rom_q),
        .i_ext_q        (ext_q),
        .i_main_q       (main_q)
    );

    // rom contents are undefined until loaded, so no clearing
    mmb_ram #(.AW(ROM_AW), .DW(8)) u_rom (
        .i_clk   (i_clk),
        .i_we    (rom_port.we),
        .i_waddr (rom_port.waddr),
        .i_wdata (rom_port.wdata),
        .i_raddr (rom_port.raddr),
        .o_rdata (rom_q)
    );

    mmb_ram #(.AW(EXT_AW), .DW(8)) u_ext (
        .i_clk   (i_clk),
        .i_we    (ext_port.we),
        .i_waddr (ext_port.waddr),
        .i_wdata (ext_port.wdata),
        .i_raddr (ext_port.raddr),
        .o_rdata (ext_q)
    );

    // main ram backs 8000-9FFF and C000-FFFF including oam and high registers
    mmb_ram #(.AW(MAIN_AW), .DW(8)) u_main (
        .i_clk   (i_clk),
        .i_we    (main_port.we),
        .i_waddr (main_port.waddr),
        .i_wdata (main_port.wdata),
        .i_raddr (main_port.raddr),
        .o_rdata (main_q)
    );

endmodule

// ----- tb/bus_scoreboard_pkg.sv -----
// scoreboard class for the memory map bus: bus map predictor and result checks
package bus_scoreboard_pkg;
    import mmb_pkg::*;

    typedef struct packed {
        logic [7:0] rdata;
        logic       serial_valid;
        logic [7:0] serial_char;
        t_fwd       fwd_target;
        logic [7:0] fwd_value;
    } t_bus_result;

    localparam int MAX_PRINTED = 100;

    class bus_scoreboard;
        logic [7:0]  rom_bytes [32768];
        logic [7:0]  ext_bytes [8192];
        logic [7:0]  main_bytes [32768];
        t_bus_result pending_results [$];
        int          errors;
        int          results_seen;
        int          dma_copies;
        int          serial_chars;
        int          fwd_writes;

        function new();
            foreach (rom_bytes[i]) begin
                rom_bytes[i] = 8'h00;
            end
            foreach (ext_bytes[i]) begin
                ext_bytes[i] = 8'h00;
            end
            foreach (main_bytes[i]) begin
                main_bytes[i] = 8'h00;
            end
            errors       = 0;
            results_seen = 0;
            dma_copies   = 0;
            serial_chars = 0;
            fwd_writes   = 0;
        endfunction

        function logic [7:0] read_map(input logic [15:0] a);
            logic [15:0] folded;
            if (!a[15]) begin
                return rom_bytes[a[14:0]];
            end
            if (a >= ADDR_EXT_LO && a <= ADDR_EXT_HI) begin
                return ext_bytes[a[12:0]];
            end
            if (a >= ADDR_ECHO_LO && a <= ADDR_ECHO_HI) begin
                folded = a - ECHO_OFFSET;
                return main_bytes[folded[14:0]];
            end
            if (a >= ADDR_ZERO_LO && a <= ADDR_ZERO_HI) begin
                return 8'h00;
            end
            return main_bytes[a[14:0]];
        endfunction

        function t_bus_result predict_access(input logic [1:0] op, input logic [15:0] addr,
                                             input logic [7:0] wdata);
            t_bus_result r;
            logic [15:0] folded;
            logic [15:0] src;
            int          i;
            r = '0;
            r.fwd_target = FWD_NONE;
            if (op == OP_READ) begin
                r.rdata = read_map(addr);
            end else if (op == OP_LOAD) begin
                if (!addr[15]) begin
                    rom_bytes[addr[14:0]] = wdata;
                end
            end else if (op == OP_WRITE) begin
                if (!addr[15] || (addr >= ADDR_ZERO_LO && addr <= ADDR_ZERO_HI)) begin
                    // rom and unused area drop the write
                end else if (addr >= ADDR_EXT_LO && addr <= ADDR_EXT_HI) begin
                    ext_bytes[addr[12:0]] = wdata;
                end else if (addr >= ADDR_ECHO_LO && addr <= ADDR_ECHO_HI) begin
                    folded = addr - ECHO_OFFSET;
                    main_bytes[folded[14:0]] = wdata;
                end else if (addr == ADDR_SC && wdata == SERIAL_START) begin
                    r.serial_valid = 1'b1;
                    r.serial_char  = main_bytes[ADDR_SB[14:0]];
                    serial_chars++;
                end else if (addr == ADDR_DIV) begin
                    r.fwd_target = FWD_DIV;
                    r.fwd_value  = wdata;
                    fwd_writes++;
                end else if (addr == ADDR_TAC) begin
                    main_bytes[ADDR_TAC[14:0]] = wdata & TAC_MASK;
                end else if (addr == ADDR_IF) begin
                    r.fwd_target = FWD_IF;
                    r.fwd_value  = wdata;
                    fwd_writes++;
                end else if (addr == ADDR_DMA) begin
                    // byte order matters: later reads see bytes already copied
                    src = {wdata, 8'h00};
                    for (i = 0; i < DMA_LENGTH; i++) begin
                        main_bytes[OAM_BASE + 15'(i)] = read_map(src + 16'(i));
                    end
                    dma_copies++;
                end else if (addr == ADDR_IE) begin
                    r.fwd_target = FWD_IE;
                    r.fwd_value  = wdata;
                    fwd_writes++;
                end else begin
                    main_bytes[addr[14:0]] = wdata;
                end
            end
            return r;
        endfunction

        function void note_access(input logic [1:0] op, input logic [15:0] addr,
                                  input logic [7:0] wdata);
            pending_results.push_back(predict_access(op, addr, wdata));
        endfunction

        task report_error(input string msg);
            if (errors < MAX_PRINTED) begin
                $display("ERROR: %s", msg);
            end
            errors++;
        endtask

        task compare_field(input string name, input logic [7:0] got, input logic [7:0] want);
            if (got !== want) begin
                report_error($sformatf("result %0d %s: got %02h, expected %02h",
                                       results_seen, name, got, want));
            end
        endtask

        task check_result(input t_bus_result got);
            t_bus_result want;
            results_seen++;
            if (pending_results.size() == 0) begin
                report_error($sformatf("result %0d arrived with nothing outstanding",
                                       results_seen));
                return;
            end
            want = pending_results.pop_front();
            compare_field("rdata", got.rdata, want.rdata);
            compare_field("serial_valid", {7'b0, got.serial_valid}, {7'b0, want.serial_valid});
            compare_field("serial_char", got.serial_char, want.serial_char);
            compare_field("fwd_target", {6'b0, got.fwd_target}, {6'b0, want.fwd_target});
            compare_field("fwd_value", got.fwd_value, want.fwd_value);
        endtask
    endclass

endpackage

// ----- tb/memory_map_bus_with_oam_dma_tb.sv -----
// testbench for the memory map bus with oam dma: directed and random bus traffic
module memory_map_bus_with_oam_dma_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mmb_pkg::*;
    import bus_scoreboard_pkg::*;

    // op code with no function, must leave state alone and return zeros
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS     = 2000;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int IDLE_LIMIT       = 150000;
    localparam int DRAIN_CYCLES     = 20;
    localparam int RECENT_DEPTH     = 32;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_op;
    logic [15:0] i_addr;
    logic [7:0]  i_wdata;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [7:0]  o_rdata;
    logic        o_serial_valid;
    logic [7:0]  o_serial_char;
    logic [1:0]  o_fwd_target;
    logic [7:0]  o_fwd_value;

    memory_map_bus_with_oam_dma uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_op           (i_op),
        .i_addr         (i_addr),
        .i_wdata        (i_wdata),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_rdata        (o_rdata),
        .o_serial_valid (o_serial_valid),
        .o_serial_char  (o_serial_char),
        .o_fwd_target   (o_fwd_target),
        .o_fwd_value    (o_fwd_value)
    );

    bus_scoreboard sb;

    // stimulus bookkeeping: rom bytes that may be read, recently written addresses
    bit          rom_written [32768];
    logic [15:0] rom_loaded_q [$];
    logic [15:0] recent_writes [$];
    int          rom_bytes_loaded = 0;

    // idle control shared by sender and receiver
    int sender_gap_max = 0;
    int recv_gap_max   = 0;
    int hold_left      = 0;
    bit long_hold_req  = 1'b0;
    int zero_gap_left  = 0;
    int items_sent     = 0;
    int idle_cycles    = 0;

    // 2 ns clock
    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // one input transfer: idle gap, present item, hold it until taken
    task automatic send_access(input logic [1:0] op, input logic [15:0] addr,
                               input logic [7:0] wdata);
        int gap;
        gap = (zero_gap_left > 0) ? 0 : $urandom_range(0, sender_gap_max);
        if (zero_gap_left > 0) begin
            zero_gap_left--;
        end
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_op       <= op;
        i_addr     <= addr;
        i_wdata    <= wdata;
        // stall is high through the clearing pass and while a dma runs
        do begin
            @(posedge i_clk);
        end while (o_in_stall !== 1'b0);
        sb.note_access(op, addr, wdata);
        if (op == OP_LOAD && !addr[15] && !rom_written[addr[14:0]]) begin
            rom_written[addr[14:0]] = 1'b1;
            rom_loaded_q.push_back(addr);
            rom_bytes_loaded++;
        end
        if (op == OP_WRITE) begin
            recent_writes.push_back(addr);
            if (recent_writes.size() > RECENT_DEPTH) begin
                void'(recent_writes.pop_front());
            end
        end
        items_sent++;
    endtask

    // drop valid and hold off until every outstanding result has come back
    task automatic wait_for_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    function automatic bit rom_page_ready(input logic [6:0] page);
        int i;
        for (i = 0; i < DMA_LENGTH; i++) begin
            if (!rom_written[{page, 8'h00} + 15'(i)]) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // dma source page; a rom page only once all of its copied bytes are loaded
    function automatic logic [7:0] pick_dma_page();
        logic [7:0] page;
        page = 8'($urandom_range(0, 255));
        if (!page[7] && !rom_page_ready(page[6:0])) begin
            page[7] = 1'b1;
        end
        return page;
    endfunction

    // address spread over every region, plus special registers and recent writes
    function automatic logic [15:0] pick_address();
        case ($urandom_range(0, 9))
            0: return ADDR_EXT_LO + 16'($urandom_range(0, 16'h1FFF));
            1: return 16'h8000 + 16'($urandom_range(0, 16'h1FFF));
            2: return 16'hC000 + 16'($urandom_range(0, 16'h1FFF));
            3: return ADDR_ECHO_LO + 16'($urandom_range(0, 16'h1DFF));
            4: return 16'hFE00 + 16'($urandom_range(0, 16'h9F));
            5: return ADDR_ZERO_LO + 16'($urandom_range(0, 16'h5F));
            6: return 16'hFF00 + 16'($urandom_range(0, 16'hFF));
            7: begin
                case ($urandom_range(0, 6))
                    0: return ADDR_SB;
                    1: return ADDR_SC;
                    2: return ADDR_DIV;
                    3: return ADDR_TAC;
                    4: return ADDR_IF;
                    5: return ADDR_DMA;
                    default: return ADDR_IE;
                endcase
            end
            8: begin
                if (recent_writes.size() > 0) begin
                    return recent_writes[$urandom_range(0, recent_writes.size() - 1)];
                end
                return 16'($urandom);
            end
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_access();
        int          sel;
        logic [1:0]  op;
        logic [15:0] addr;
        logic [7:0]  data;
        sel  = $urandom_range(0, 99);
        data = 8'($urandom_range(0, 255));
        if (sel < 40) begin
            op = OP_READ;
            if (rom_loaded_q.size() > 0 && $urandom_range(0, 4) == 0) begin
                addr = rom_loaded_q[$urandom_range(0, rom_loaded_q.size() - 1)];
            end else begin
                addr = pick_address();
            end
            // never read a rom byte that has not been loaded
            if (!addr[15] && !rom_written[addr[14:0]]) begin
                addr[15] = 1'b1;
            end
        end else if (sel < 80) begin
            op   = OP_WRITE;
            addr = pick_address();
            if (addr == ADDR_DMA) begin
                data = pick_dma_page();
            end else if (addr == ADDR_SC && $urandom_range(0, 1) == 1) begin
                data = SERIAL_START;
            end
        end else if (sel < 98) begin
            op = OP_LOAD;
            // mostly in range, some above 7FFF which must be ignored
            addr = ($urandom_range(0, 3) == 0) ? 16'($urandom) : {1'b0, 15'($urandom)};
        end else begin
            op   = OP_UNUSED;
            addr = 16'($urandom);
        end
        send_access(op, addr, data);
    endtask

    // load the 160 copied bytes of a rom page, copy them into oam, then read some of the copy back
    task automatic rom_page_dma();
        logic [6:0] page;
        int         i;
        page = 7'($urandom_range(0, 127));
        for (i = 0; i < DMA_LENGTH; i++) begin
            send_access(OP_LOAD, {1'b0, page, 8'h00} + 16'(i), 8'($urandom_range(0, 255)));
        end
        send_access(OP_WRITE, ADDR_DMA, {1'b0, page});
        for (i = 0; i < 4; i++) begin
            send_access(OP_READ, 16'hFE00 + 16'($urandom_range(0, DMA_LENGTH - 1)),
                        8'($urandom_range(0, 255)));
        end
    endtask

    task automatic run_directed();
        sender_gap_max = 15;
        recv_gap_max   = 15;
        // rom extremes, loaded then read back
        send_access(OP_LOAD, 16'h0000, 8'hFF);
        send_access(OP_LOAD, 16'h7FFF, 8'h5A);
        send_access(OP_READ, 16'h0000, 8'h00);
        send_access(OP_READ, 16'h7FFF, 8'hFF);
        // write to rom is dropped, load above 7FFF is dropped
        send_access(OP_WRITE, 16'h0000, 8'h12);
        send_access(OP_READ, 16'h0000, 8'h00);
        send_access(OP_LOAD, 16'h8000, 8'hEE);
        // external ram top byte
        send_access(OP_WRITE, ADDR_EXT_HI, 8'h3C);
        send_access(OP_READ, ADDR_EXT_HI, 8'h00);
        // echo both ways: write below, read echo; write echo top, read below
        send_access(OP_WRITE, 16'hC000, 8'h77);
        send_access(OP_READ, ADDR_ECHO_LO, 8'h00);
        send_access(OP_WRITE, ADDR_ECHO_HI, 8'h99);
        send_access(OP_READ, 16'hDDFF, 8'h00);
        // unused area drops writes and reads zero
        send_access(OP_WRITE, ADDR_ZERO_LO, 8'h44);
        send_access(OP_READ, ADDR_ZERO_HI, 8'h00);
        // serial: trigger value emits, any other value is stored
        send_access(OP_WRITE, ADDR_SB, 8'h55);
        send_access(OP_WRITE, ADDR_SC, SERIAL_START);
        send_access(OP_WRITE, ADDR_SC, 8'h80);
        // forwarded writes; interrupt enable reads back as never written
        send_access(OP_WRITE, ADDR_DIV, 8'hFF);
        send_access(OP_WRITE, ADDR_IF, 8'h1F);
        send_access(OP_WRITE, ADDR_IE, 8'hE1);
        send_access(OP_READ, ADDR_IE, 8'h00);
        // timer control keeps the low 3 bits
        send_access(OP_WRITE, ADDR_TAC, 8'hFF);
        send_access(OP_READ, ADDR_TAC, 8'h00);
        // oam dma from C000, first copied byte read back
        send_access(OP_WRITE, ADDR_DMA, 8'hC0);
        send_access(OP_READ, 16'hFE00, 8'h00);
        // unused op code
        send_access(OP_UNUSED, 16'hFFFF, 8'hFF);
    endtask

    task automatic run_random();
        int start;
        int k;
        int bursts_done;
        bit hold_done;
        bit pause_done;
        start       = items_sent;
        bursts_done = 0;
        hold_done   = 1'b0;
        pause_done  = 1'b0;
        while (items_sent - start < RANDOM_ITEMS) begin
            k = items_sent - start;
            // now and then switch between busy and idling behavior on both sides
            if ($urandom_range(0, 149) == 0) begin
                sender_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 15;
                recv_gap_max   = ($urandom_range(0, 2) == 0) ? 0 : 15;
            end
            if (!hold_done && k >= 600) begin
                // receiver holds off long while sender keeps pushing back to back
                long_hold_req = 1'b1;
                zero_gap_left = 40;
                hold_done     = 1'b1;
            end
            if (!pause_done && k >= 1200) begin
                wait_for_results();
                pause_done = 1'b1;
            end
            if (bursts_done < 2 && k >= 300 + 700 * bursts_done) begin
                rom_page_dma();
                bursts_done++;
            end else begin
                random_access();
            end
        end
    endtask

    // receiver: stall counted down here, including the long hold-off
    initial begin : receiver
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // result transfers go to the scoreboard, then a new stall length is drawn
    always @(posedge i_clk) begin : result_monitor
        t_bus_result got;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            got.rdata        = o_rdata;
            got.serial_valid = o_serial_valid;
            got.serial_char  = o_serial_char;
            got.fwd_target   = t_fwd'(o_fwd_target);
            got.fwd_value    = o_fwd_value;
            sb.check_result(got);
            hold_left = $urandom_range(0, recv_gap_max);
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge i_clk) begin
        if ((i_in_valid === 1'b1 && o_in_stall === 1'b0) ||
            (o_out_valid === 1'b1 && i_out_stall === 1'b0)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin : stimulus
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_op        = OP_READ;
        i_addr      = 16'h0000;
        i_wdata     = 8'h00;
        sb = new();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // first transfer waits out the clearing pass on its own stall
        run_directed();
        wait_for_results();
        run_random();
        wait_for_results();
        // nothing further may come out
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("run covered %0d bus transfers, %0d results, %0d oam dma copies",
                 items_sent, sb.results_seen, sb.dma_copies);
        $display("with %0d serial characters, %0d forwarded writes, %0d rom bytes loaded",
                 sb.serial_chars, sb.fwd_writes, rom_bytes_loaded);
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/mmb_pkg.sv
rtl/mmb_ram.sv
rtl/mmb_seq.sv
rtl/memory_map_bus_with_oam_dma.sv
tb/bus_scoreboard_pkg.sv
tb/memory_map_bus_with_oam_dma_tb.sv
